FILE: rtl/core/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// shared types and codes for the bitmap first-fit page allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MapWordBits = 64;
    localparam int PageBits    = 17;
    localparam int IndexBits   = 16;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_RESERVE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_RUN    = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_DBL_FREE  = 3'd4
    } status_t;

    typedef logic [MapWordBits-1:0] map_word_t;
    typedef logic [PageBits-1:0]    page_t;

    // result of searching one map word for the end of a free run
    typedef struct packed {
        logic       hit;
        logic [5:0] pos;
        page_t      carry;
    } find_t;

    function automatic logic [6:0] popcount64(input map_word_t w);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < MapWordBits; i++) begin
            n = n + {6'd0, w[i]};
        end
        return n;
    endfunction

    // word-level mask of pages at or above a bound
    function automatic map_word_t mask_at_or_above(input page_t word_idx, input page_t bound);
        page_t bw;
        bw = bound >> 6;
        if (word_idx > bw) begin
            return '1;
        end
        else if (word_idx == bw) begin
            return map_word_t'('1) << bound[5:0];
        end
        else begin
            return '0;
        end
    endfunction

endpackage

FILE: rtl/core/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bffa_run_find.sv
// ----------------------------------------------------------------------------
// bffa_run_find
// finds the first page in one map word that completes a free run
// ----------------------------------------------------------------------------
module bffa_run_find
    import bffa_pkg::*;
(
    input  map_word_t used,     // used bits, out-of-window pages forced to one
    input  page_t     carry,    // free run length entering bit 0
    input  page_t     run_len,
    output find_t     result
);

    logic [17:0] run   [MapWordBits];
    logic        hitv  [MapWordBits];

    always_comb
    begin
        map_word_t m;
        logic [5:0] msb;
        for (int j = 0; j < MapWordBits; j++) begin
            m   = used & (map_word_t'('1) >> (MapWordBits - 1 - j));
            msb = '0;
            for (int k = 0; k < MapWordBits; k++) begin
                if (m[k]) begin
                    msb = 6'(k);
                end
            end
            if (m == '0) begin
                run[j] = {1'b0, carry} + 18'(j + 1);
            end
            else begin
                run[j] = 18'(j) - {12'd0, msb};
            end
            hitv[j] = !used[j] && (run[j] >= {1'b0, run_len});
        end
    end

    always_comb
    begin
        result.hit = 1'b0;
        result.pos = '0;
        for (int j = MapWordBits - 1; j >= 0; j--) begin
            if (hitv[j]) begin
                result.hit = 1'b1;
                result.pos = 6'(j);
            end
        end
        result.carry = run[MapWordBits-1][PageBits-1:0];
    end

endmodule

FILE: rtl/core/bitmap_first_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator_unit
// one-bit-per-page used map with first-fit run allocation
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request word: action, page_index, run_length. each
//   request yields exactly one response word on m_axis: status, run start
//   page and the free page count after the request.
//   cfg writes total_pages (index 0) or guard_pages (index 1); write only
//   while no request is outstanding.
// timing
//   the map lives in a ram of 64-bit words, MAX_PAGES/64 deep, with one
//   registered read port. allocate streams one word per cycle through the
//   run finder from the guard word upward, then marks the run with a read
//   (S_RD) and a write-back (S_WR) of each word. free runs a check pass that
//   only reads and then a clear pass, release and reserve one pass; each
//   write pass reads and writes back every word touched. a zero length or
//   an out of range request goes straight to the response state. one request is in work at a time.
// reset
//   after reset a clearing pass writes all-ones (every page used) into all
//   MAX_PAGES/64 words, one per cycle; s_axis_tready stays low meanwhile.
//   free count resets to zero, total_pages to 0, guard_pages to 256.
// stall
//   a finished response sits in the output register; the block takes the
//   next request while it waits, and holds the following one until it is taken
// ----------------------------------------------------------------------------
module bitmap_first_fit_page_allocator_unit
    import bffa_pkg::*;
#(
    parameter int MAX_PAGES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // request: [1:0] action, [17:2] page_index, [34:18] run_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // response: [2:0] status, [18:3] run_start, [35:19] free_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata
);

    localparam int Words = MAX_PAGES / MapWordBits;
    localparam int AW    = $clog2(Words);
    localparam int FW    = $clog2(MAX_PAGES + 1);
    localparam logic [20:0] MaxP = 21'(MAX_PAGES);

    localparam logic [7:0] RegTotal = 8'd0;
    localparam logic [7:0] RegGuard = 8'd1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_RD, S_WR, S_RESP
    } state_t;

    state_t          state_reg, state_next;
    page_t           total_reg, guard_reg;
    logic [FW-1:0]   free_reg, free_next;
    logic [AW-1:0]   word_reg, word_next;
    logic [AW:0]     issue_reg, issue_next;
    logic [AW:0]     last_reg, last_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_w_reg, pend_w_next;
    page_t           carry_reg, carry_next;
    page_t           lo_reg, lo_next, hi_reg, hi_next, len_reg, len_next;
    logic            set_reg, set_next;          // set bits (alloc, reserve)
    logic            grd_reg, grd_next;          // skip guarded pages (release)
    logic            chk_reg, chk_next;          // double free check pass
    status_t         status_reg, status_next;
    logic [15:0]     start_reg, start_next;
    logic            ovalid_reg, ovalid_next;
    logic [39:0]     odata_reg, odata_next;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    map_word_t       mem_wdata, mem_rdata;

    page_t           eff_total;
    find_t           fres;
    map_word_t       scan_used, rng_mask, chg;
    page_t           pend_page, word_page;

    action_t         in_act;
    page_t           in_first, in_len;
    logic [17:0]     in_end;

    function automatic logic [AW-1:0] to_word(input page_t p);
        page_t t;
        t = p >> 6;
        return t[AW-1:0];
    endfunction

    assign eff_total = ({4'd0, total_reg} > MaxP) ? MaxP[PageBits-1:0] : total_reg;
    assign in_act    = action_t'(s_axis_tdata[1:0]);
    assign in_first  = {1'b0, s_axis_tdata[17:2]};
    assign in_len    = s_axis_tdata[34:18];
    assign in_end    = {1'b0, in_first} + {1'b0, in_len};

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg <= '0;
            guard_reg <= 17'd256;
        end
        else if (cfg_valid) begin
            if (cfg_index == RegTotal) begin
                total_reg <= cfg_data;
            end
            else if (cfg_index == RegGuard) begin
                guard_reg <= cfg_data;
            end
        end
    end

    bffa_ram #(
        .WIDTH (MapWordBits),
        .DEPTH (Words)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // scan window: pages in [guard, total) count as candidates
    assign pend_page = page_t'({{(21 - AW){1'b0}}, pend_w_reg});
    assign scan_used = mem_rdata
                     | ~(mask_at_or_above(pend_page, guard_reg)
                         & ~mask_at_or_above(pend_page, eff_total));

    bffa_run_find u_find (
        .used    (scan_used),
        .carry   (carry_reg),
        .run_len (len_reg),
        .result  (fres)
    );

    // range mask for the word in the read-modify-write pass
    assign word_page = page_t'({{(21 - AW){1'b0}}, word_reg});
    always_comb
    begin
        logic [5:0] lb, hb;
        lb = (word_reg == to_word(lo_reg)) ? lo_reg[5:0] : 6'd0;
        hb = (word_reg == to_word(hi_reg)) ? hi_reg[5:0] : 6'd63;
        rng_mask = (map_word_t'('1) << lb) & (map_word_t'('1) >> (6'd63 - hb));
        if (grd_reg) begin
            rng_mask = rng_mask & mask_at_or_above(word_page, guard_reg);
        end
        chg = set_reg ? (rng_mask & ~mem_rdata) : (rng_mask & mem_rdata);
    end

    always_comb
    begin
        page_t      e, s;
        logic [22:0] ep;
        state_next  = state_reg;
        free_next   = free_reg;
        word_next   = word_reg;
        issue_next  = issue_reg;
        last_next   = last_reg;
        pend_next   = 1'b0;
        pend_w_next = pend_w_reg;
        carry_next  = carry_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        len_next    = len_reg;
        set_next    = set_reg;
        grd_next    = grd_reg;
        chk_next    = chk_reg;
        status_next = status_reg;
        start_next  = start_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        mem_we      = 1'b0;
        mem_waddr   = word_reg;
        mem_wdata   = '1;
        mem_re      = 1'b0;
        mem_raddr   = word_reg;
        ep          = '0;
        e           = '0;
        s           = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                word_next = word_reg + 1'b1;
                if (word_reg == AW'(Words - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    status_next = ST_OK;
                    start_next  = '0;
                    len_next    = in_len;
                    lo_next     = in_first;
                    hi_next     = page_t'(in_end - 18'd1);
                    word_next   = to_word(in_first);
                    chk_next    = 1'b0;
                    grd_next    = 1'b0;
                    set_next    = 1'b0;
                    state_next  = S_RD;
                    if (in_len == '0) begin
                        status_next = ST_ZERO_LEN;
                        state_next  = S_RESP;
                    end
                    else if (in_act == ACT_ALLOC) begin
                        if (guard_reg >= eff_total) begin
                            status_next = ST_NO_RUN;
                            state_next  = S_RESP;
                        end
                        else begin
                            issue_next = {1'b0, to_word(guard_reg)};
                            last_next  = {1'b0, to_word(eff_total - 17'd1)};
                            carry_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (in_end > {1'b0, eff_total}) begin
                        status_next = ST_RANGE;
                        state_next  = S_RESP;
                    end
                    else begin
                        unique case (in_act)
                            ACT_FREE:    chk_next = 1'b1;
                            ACT_RELEASE: grd_next = 1'b1;
                            ACT_RESERVE: set_next = 1'b1;
                            default:     set_next = 1'b1;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg <= last_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = issue_reg[AW-1:0];
                    pend_next   = 1'b1;
                    pend_w_next = issue_reg[AW-1:0];
                    issue_next  = issue_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (fres.hit) begin
                        ep         = 23'({pend_w_reg, fres.pos});
                        e          = ep[PageBits-1:0];
                        s          = e - len_reg + 17'd1;
                        lo_next    = s;
                        hi_next    = e;
                        word_next  = to_word(s);
                        set_next   = 1'b1;
                        start_next = s[15:0];
                        pend_next  = 1'b0;
                        state_next = S_RD;
                    end
                    else begin
                        carry_next = fres.carry;
                    end
                end
                else if (issue_reg > last_reg) begin
                    status_next = ST_NO_RUN;
                    state_next  = S_RESP;
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                state_next = S_RD;
                if (chk_reg) begin
                    if ((rng_mask & ~mem_rdata) != '0) begin
                        status_next = ST_DBL_FREE;
                        state_next  = S_RESP;
                    end
                    else if (word_reg == to_word(hi_reg)) begin
                        chk_next  = 1'b0;
                        word_next = to_word(lo_reg);
                    end
                    else begin
                        word_next = word_reg + 1'b1;
                    end
                end
                else begin
                    mem_we    = 1'b1;
                    mem_wdata = set_reg ? (mem_rdata | rng_mask) : (mem_rdata & ~chg);
                    free_next = set_reg ? (free_reg - FW'(popcount64(chg)))
                                        : (free_reg + FW'(popcount64(chg)));
                    word_next = word_reg + 1'b1;
                    if (word_reg == to_word(hi_reg)) begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!ovalid_reg || m_axis_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    odata_next[2:0]  = status_reg;
                    odata_next[18:3] = start_reg;
                    odata_next[35:19] = (21'(free_reg) > 21'h1FFFF) ? 17'h1FFFF
                                                                     : 17'(free_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_CLEAR;
            free_reg   <= '0;
            word_reg   <= '0;
            issue_reg  <= '0;
            last_reg   <= '0;
            pend_reg   <= 1'b0;
            pend_w_reg <= '0;
            carry_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            len_reg    <= '0;
            set_reg    <= 1'b0;
            grd_reg    <= 1'b0;
            chk_reg    <= 1'b0;
            status_reg <= ST_OK;
            start_reg  <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            word_reg   <= word_next;
            issue_reg  <= issue_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            pend_w_reg <= pend_w_next;
            carry_reg  <= carry_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            len_reg    <= len_next;
            set_reg    <= set_next;
            grd_reg    <= grd_next;
            chk_reg    <= chk_next;
            status_reg <= status_next;
            start_reg  <= start_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
        end
    end

    // no request taken while the map is being initialized
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during map init");

    // the scan only reads the map
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_we)
        else $error("map write during scan");

    // free count never exceeds the map size
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        21'(free_reg) <= MaxP)
        else $error("free count beyond map size");

    // a write-back always follows a read of the same word
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_WR) |-> $past(state_reg == S_RD))
        else $error("write-back without read");

endmodule

FILE: tb/tb_bitmap_first_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_bitmap_first_fit_page_allocator_unit
// self-checking bench for the bitmap first-fit page allocator
// ----------------------------------------------------------------------------
// request words are queued by a stimulus process and fed to s_axis by a
// driver on the falling edge; every accepted request is run through a local
// model of the page map, and the response it predicts is matched against the
// words taken from m_axis. both sides insert random gaps, except in one
// phase that runs gap-free. total_pages and guard_pages are changed between
// phases, only after every response has come back.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_page_allocator_unit;
    import bffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MaxPages   = 65536;
    localparam logic [7:0]  RegTotal   = 8'd0;
    localparam logic [7:0]  RegGuard   = 8'd1;
    localparam int          GapPercent = 13;
    localparam longint      CycleLimit = 20000000;

    typedef struct {
        action_t     act;
        logic [15:0] idx;
        logic [16:0] len;
    } page_request_t;

    typedef struct {
        status_t     st;
        logic [15:0] start;
        logic [16:0] fc;
    } alloc_response_t;

    typedef struct {
        int unsigned start;
        int unsigned len;
    } page_run_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    // pending request words, front is the one on the bus
    page_request_t   pending_requests[$];
    alloc_response_t expected_responses[$];
    // runs handed out by allocate, used to build legal frees
    page_run_t       live_runs[$];

    // local copy of the allocator state
    bit          used_map[MaxPages];
    int unsigned free_cnt;
    int unsigned total_cfg;
    int unsigned guard_cfg;

    int     errors;
    longint cycles;
    bit     word_taken;
    bit     no_gaps;

    bitmap_first_fit_page_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // action, page_index, run_length
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // status, run_start, free_count
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // model of one request, applied when the word is accepted
    function automatic void predict_request(page_request_t r);
        int unsigned     tot;
        int unsigned     len;
        int unsigned     first;
        int unsigned     run;
        int unsigned     s;
        int unsigned     p;
        bit              found;
        bit              dbl;
        alloc_response_t e;
        page_run_t       pr;
        tot   = (total_cfg > MaxPages) ? MaxPages : total_cfg;
        len   = r.len;
        first = r.idx;
        e.st    = ST_OK;
        e.start = '0;
        found = 1'b0;
        dbl   = 1'b0;
        run   = 0;
        s     = 0;
        if (len == 0) begin
            e.st = ST_ZERO_LEN;
        end
        else if (r.act == ACT_ALLOC) begin
            // first fit upward from the guard
            for (int unsigned i = guard_cfg; i < tot; i++) begin
                if (!used_map[i]) begin
                    if (run == 0) s = i;
                    run++;
                    if (run >= len) begin
                        found = 1'b1;
                        break;
                    end
                end
                else begin
                    run = 0;
                end
            end
            if (found) begin
                for (int unsigned i = 0; i < len; i++) used_map[s + i] = 1'b1;
                free_cnt -= len;
                e.start = s[15:0];
                pr.start = s;
                pr.len   = len;
                live_runs.push_back(pr);
            end
            else begin
                e.st = ST_NO_RUN;
            end
        end
        else if (first + len > tot) begin
            e.st = ST_RANGE;
        end
        else if (r.act == ACT_FREE) begin
            // refuse the whole range if any page is already free
            for (int unsigned i = 0; i < len; i++) begin
                if (!used_map[first + i]) dbl = 1'b1;
            end
            if (dbl) begin
                e.st = ST_DBL_FREE;
            end
            else begin
                for (int unsigned i = 0; i < len; i++) used_map[first + i] = 1'b0;
                free_cnt += len;
            end
        end
        else if (r.act == ACT_RELEASE) begin
            // guarded pages are skipped, already free pages not counted twice
            for (int unsigned i = 0; i < len; i++) begin
                p = first + i;
                if (p >= guard_cfg && used_map[p]) begin
                    used_map[p] = 1'b0;
                    free_cnt++;
                end
            end
        end
        else begin
            for (int unsigned i = 0; i < len; i++) begin
                p = first + i;
                if (!used_map[p]) begin
                    used_map[p] = 1'b1;
                    free_cnt--;
                end
            end
        end
        e.fc = (free_cnt > 32'h1FFFF) ? 17'h1FFFF : free_cnt[16:0];
        expected_responses.push_back(e);
    endfunction

    // request side: accept at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready && !word_taken) begin
            predict_request(pending_requests[0]);
            void'(pending_requests.pop_front());
            word_taken = 1'b1;
        end
    end

    // request side: drive at the falling edge
    always @(negedge clk)
    begin
        if (!(s_axis_tvalid && !word_taken)) begin
            s_axis_tvalid = 1'b0;
            if (pending_requests.size() > 0 &&
                (no_gaps || $urandom_range(99) >= GapPercent)) begin
                s_axis_tdata  = {5'd0, pending_requests[0].len,
                                 pending_requests[0].idx, pending_requests[0].act};
                s_axis_tvalid = 1'b1;
                word_taken    = 1'b0;
            end
        end
    end

    // response side: random backpressure
    always @(negedge clk)
    begin
        m_axis_tready = no_gaps || ($urandom_range(99) >= GapPercent);
    end

    // response side: check each accepted word against the oldest prediction
    always @(posedge clk)
    begin
        alloc_response_t e;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout", $realtime);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected response word %h", $realtime, m_axis_tdata);
                errors++;
            end
            else begin
                e = expected_responses.pop_front();
                if (m_axis_tdata[2:0] !== e.st || m_axis_tdata[18:3] !== e.start ||
                    m_axis_tdata[35:19] !== e.fc) begin
                    $display("%0t: mismatch expected st=%0d start=%0d free=%0d",
                             $realtime, e.st, e.start, e.fc);
                    $display("%0t:          actual   st=%0d start=%0d free=%0d",
                             $realtime, m_axis_tdata[2:0], m_axis_tdata[18:3],
                             m_axis_tdata[35:19]);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = val[16:0];
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == RegTotal) total_cfg = val & 32'h1FFFF;
        else guard_cfg = val & 32'h1FFFF;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_request(input action_t a, input int unsigned idx,
                               input int unsigned len);
        page_request_t r;
        r.act = a;
        r.idx = idx[15:0];
        r.len = len[16:0];
        pending_requests.push_back(r);
    endtask

    // wait until every request is taken and answered
    task automatic drain();
        while (pending_requests.size() > 0 || expected_responses.size() > 0 ||
               (s_axis_tvalid && !word_taken))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one random request, mostly legal traffic around the live runs
    task automatic add_random_request();
        int unsigned tot;
        int unsigned k;
        int unsigned pick;
        int unsigned idx;
        int unsigned len;
        page_run_t   pr;
        tot  = (total_cfg > MaxPages) ? MaxPages : total_cfg;
        pick = $urandom_range(99);
        if (pick < 40) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(MaxPages, 1)
                                            : $urandom_range(32, 1);
            add_request(ACT_ALLOC, $urandom, len);
        end
        else if (pick < 70 && live_runs.size() > 0) begin
            k  = $urandom_range(live_runs.size() - 1);
            pr = live_runs[k];
            live_runs.delete(k);
            // sometimes spill over the end of the run
            if ($urandom_range(9) == 0) pr.len = pr.len + $urandom_range(2);
            add_request(ACT_FREE, pr.start, pr.len);
        end
        else if (pick < 80 && tot > 0) begin
            idx = $urandom_range(tot - 1);
            add_request(ACT_RELEASE, idx, $urandom_range(tot - idx, 1));
        end
        else if (pick < 88 && tot > 0) begin
            idx = $urandom_range(tot - 1);
            len = $urandom_range(((tot - idx) < 48) ? (tot - idx) : 48, 1);
            add_request(ACT_RESERVE, idx, len);
        end
        else begin
            add_request(action_t'($urandom_range(3)), $urandom_range(65535),
                        $urandom_range(131071));
        end
    endtask

    initial
    begin
        int unsigned totals[8];
        int unsigned guards[8];
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycles        = 0;
        word_taken    = 1'b1;
        no_gaps       = 1'b0;
        foreach (used_map[i]) used_map[i] = 1'b1;
        free_cnt  = 0;
        total_cfg = 0;
        guard_cfg = 256;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on a 4096 page map
        write_reg(RegTotal, 4096);
        write_reg(RegGuard, 256);
        add_request(ACT_ALLOC, 0, 1);              // empty map, no run
        add_request(ACT_RELEASE, 0, 4096);         // guarded pages skipped
        add_request(ACT_RELEASE, 0, 4096);         // nothing counted again
        add_request(ACT_ALLOC, 0, 0);              // zero length on every action
        add_request(ACT_FREE, 5, 0);
        add_request(ACT_RELEASE, 5, 0);
        add_request(ACT_RESERVE, 5, 0);
        add_request(ACT_ALLOC, 16'hFFFF, 1);       // page_index ignored
        add_request(ACT_ALLOC, 0, 100);
        add_request(ACT_FREE, 256, 1);
        add_request(ACT_FREE, 256, 1);             // double free
        add_request(ACT_FREE, 0, 10);              // free below the guard
        add_request(ACT_ALLOC, 0, 65536);          // longer than the space
        add_request(ACT_RESERVE, 4000, 96);
        add_request(ACT_RESERVE, 3990, 106);       // partly used already
        add_request(ACT_FREE, 4095, 2);            // past the end
        add_request(ACT_RELEASE, 65535, 65536);
        add_request(ACT_RESERVE, 65535, 1);
        add_request(ACT_FREE, 0, 131071);
        add_request(ACT_FREE, 3990, 106);
        add_request(ACT_ALLOC, 0, 3);
        drain();

        totals = '{4096, 65536, 131071, 0, 1024, 65536, 2048, 8192};
        guards = '{0, 0, 65535, 256, 1000, 256, 4096, 65536};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(RegTotal, totals[ph]);
            write_reg(RegGuard, guards[ph]);
            live_runs.delete();
            no_gaps = (ph == 1);
            add_request(ACT_RELEASE, 0, totals[ph] > MaxPages ? MaxPages : totals[ph]);
            for (int b = 0; b < 9; b++) begin
                for (int n = 0; n < 8; n++) add_random_request();
                drain();
            end
        end
        no_gaps = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
